// ===== rtl/sem_pkg.sv =====
package sem_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W;
  localparam int ENERGY_W = 11;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int GRAD_W  = CHAN_W + 2;
  localparam int SQ_W    = 2 * GRAD_W + 1;
  localparam int ROOT_W  = 11;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 3;
  localparam int STEP_W  = $clog2(ROOT_W);
  localparam int SUM_W   = ROOT_W + 2;
  localparam int DIV3_SHIFT = 13;
  localparam int RECIP_W = 12;
  localparam logic [RECIP_W-1:0] DIV3_RECIP = 12'd2731;
  localparam int PROD_W  = SUM_W + RECIP_W;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic [2:0][2:0][PIX_W-1:0] win;
    logic                       row_end;
    logic                       frame_end;
  } job_t;

endpackage

// ===== rtl/sem_if.sv =====
interface sem_pixel_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [sem_pkg::CHAN_W-1:0] red;
  logic [sem_pkg::CHAN_W-1:0] green;
  logic [sem_pkg::CHAN_W-1:0] blue;

  modport source (output valid, action, red, green, blue, input ready);
  modport sink   (input valid, action, red, green, blue, output ready);
endinterface

interface sem_result_if;
  logic                        valid;
  logic                        ready;
  logic [sem_pkg::ENERGY_W-1:0] energy;
  logic                        row_end;
  logic                        frame_end;

  modport source (output valid, energy, row_end, frame_end, input ready);
  modport sink   (input valid, energy, row_end, frame_end, output ready);
endinterface

// ===== rtl/sem_front.sv =====
module sem_front (
  input  logic                              clk,
  input  logic                              rst,
  sem_pixel_if.sink                         pixel,
  input  logic                              cfg_we,
  input  logic [sem_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              space,
  output logic                              push,
  output sem_pkg::job_t                     push_job
);

  localparam logic F_IDLE = 1'b0;
  localparam logic F_WORK = 1'b1;

  logic                               fstate;
  logic [sem_pkg::WIDTH_REG_W-1:0]    frame_width;
  logic [sem_pkg::HEIGHT_REG_W-1:0]   frame_height;
  logic [sem_pkg::COL_W-1:0]          col;
  logic [sem_pkg::ROW_W-1:0]          row;
  logic [2:0][2:0][sem_pkg::PIX_W-1:0] win;
  logic [2:0][2:0][sem_pkg::PIX_W-1:0] win_next;
  logic [2:0][2:0][sem_pkg::PIX_W-1:0] win_shift;
  logic [2:0][2:0][sem_pkg::PIX_W-1:0] win_zero;
  sem_pkg::pixel_t                    pix_q;
  logic [2*sem_pkg::PIX_W-1:0]        rd;
  logic [2*sem_pkg::PIX_W-1:0]        mem [sem_pkg::MAX_WIDTH];

  logic [sem_pkg::WIDTH_REG_W-1:0]    w_use;
  logic [sem_pkg::HEIGHT_REG_W-1:0]   h_use;
  logic [sem_pkg::COL_W-1:0]          col_eff;
  logic [sem_pkg::WIDTH_REG_W-1:0]    col_inc;
  logic [sem_pkg::ROW_W-1:0]          h_plus1;
  logic [2:0][sem_pkg::PIX_W-1:0]     new_col;
  logic                               fire;
  logic                               at_col0;
  logic                               flush_done;
  logic                               mem_we;

  always_comb begin
    if (frame_width < sem_pkg::WIDTH_REG_W'(2)) begin
      w_use = sem_pkg::WIDTH_REG_W'(2);
    end else if (frame_width > sem_pkg::WIDTH_REG_W'(sem_pkg::MAX_WIDTH)) begin
      w_use = sem_pkg::WIDTH_REG_W'(sem_pkg::MAX_WIDTH);
    end else begin
      w_use = frame_width;
    end
    if (frame_height < sem_pkg::HEIGHT_REG_W'(2)) begin
      h_use = sem_pkg::HEIGHT_REG_W'(2);
    end else if (frame_height > sem_pkg::HEIGHT_REG_W'(sem_pkg::MAX_HEIGHT)) begin
      h_use = sem_pkg::HEIGHT_REG_W'(sem_pkg::MAX_HEIGHT);
    end else begin
      h_use = frame_height;
    end
  end

  assign col_eff  = (sem_pkg::WIDTH_REG_W'(col) >= w_use) ? '0 : col;
  assign col_inc  = sem_pkg::WIDTH_REG_W'(col_eff) + sem_pkg::WIDTH_REG_W'(1);
  assign h_plus1  = sem_pkg::ROW_W'(h_use) + sem_pkg::ROW_W'(1);
  assign at_col0  = (col_eff == '0);
  assign flush_done = at_col0 && (row >= h_plus1);

  assign pixel.ready = (fstate == F_IDLE) && space;
  assign fire        = pixel.valid && pixel.ready;

  // rows outside the frame read as zero
  always_comb begin
    new_col[0] = (row >= sem_pkg::ROW_W'(2)) ? rd[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W] : '0;
    new_col[1] = (row >= sem_pkg::ROW_W'(1)) ? rd[sem_pkg::PIX_W-1:0] : '0;
    new_col[2] = pix_q;
    for (int r = 0; r < 3; r++) begin
      win_shift[r][0] = win[r][1];
      win_shift[r][1] = win[r][2];
      win_shift[r][2] = new_col[r];
      win_zero[r][0]  = win[r][1];
      win_zero[r][1]  = win[r][2];
      win_zero[r][2]  = '0;
      win_next[r][0]  = '0;
      win_next[r][1]  = '0;
      win_next[r][2]  = new_col[r];
    end
  end

  always_comb begin
    push     = 1'b0;
    push_job = '0;
    if (fstate == F_WORK) begin
      if (at_col0) begin
        push               = (row >= sem_pkg::ROW_W'(2));
        push_job.win       = win_zero;
        push_job.row_end   = 1'b1;
        push_job.frame_end = (row == h_plus1);
      end else begin
        push         = (row >= sem_pkg::ROW_W'(1));
        push_job.win = win_shift;
      end
    end
  end

  assign mem_we = (fstate == F_WORK) && !flush_done;

  always_ff @(posedge clk) begin
    if (fire) begin
      rd <= mem[col_eff];
    end
    if (mem_we) begin
      mem[col_eff] <= {rd[sem_pkg::PIX_W-1:0], pix_q};
    end
    if (fire) begin
      pix_q <= (pixel.action || (row >= sem_pkg::ROW_W'(h_use))) ? '0 :
               {pixel.red, pixel.green, pixel.blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate       <= F_IDLE;
      frame_width  <= sem_pkg::WIDTH_REG_W'(sem_pkg::MAX_WIDTH);
      frame_height <= sem_pkg::HEIGHT_REG_W'(sem_pkg::MAX_HEIGHT);
      col          <= '0;
      row          <= '0;
      win          <= '0;
    end else if (cfg_we) begin
      // restart the frame on any register write
      if (cfg_index == sem_pkg::REG_FRAME_WIDTH) begin
        frame_width <= cfg_data[sem_pkg::WIDTH_REG_W-1:0];
        col <= '0;
        row <= '0;
        win <= '0;
      end else if (cfg_index == sem_pkg::REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data[sem_pkg::HEIGHT_REG_W-1:0];
        col <= '0;
        row <= '0;
        win <= '0;
      end
    end else begin
      case (fstate)
        F_IDLE: begin
          if (fire) begin
            fstate <= F_WORK;
          end
        end
        F_WORK: begin
          fstate <= F_IDLE;
          if (flush_done) begin
            col <= '0;
            row <= '0;
            win <= '0;
          end else begin
            win <= at_col0 ? win_next : win_shift;
            if (col_inc >= w_use) begin
              col <= '0;
              row <= row + sem_pkg::ROW_W'(1);
            end else begin
              col <= col_inc[sem_pkg::COL_W-1:0];
            end
          end
        end
        default: fstate <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sem_queue.sv =====
module sem_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  sem_pkg::job_t                 push_job,
  input  logic                          pop,
  output sem_pkg::job_t                 head,
  output logic [sem_pkg::QCNT_W-1:0]    count
);

  sem_pkg::job_t               slots [sem_pkg::QUEUE_DEPTH];
  logic [sem_pkg::QPTR_W-1:0]  wr_ptr;
  logic [sem_pkg::QPTR_W-1:0]  rd_ptr;

  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == sem_pkg::QPTR_W'(sem_pkg::QUEUE_DEPTH - 1)) ? '0 :
                  wr_ptr + sem_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == sem_pkg::QPTR_W'(sem_pkg::QUEUE_DEPTH - 1)) ? '0 :
                  rd_ptr + sem_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + sem_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - sem_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/sem_back.sv =====
module sem_back (
  input  logic                        clk,
  input  logic                        rst,
  input  sem_pkg::job_t               head,
  input  logic [sem_pkg::QCNT_W-1:0]  count,
  output logic                        pop,
  sem_result_if.source                result
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_GRAD = 3'd1;
  localparam logic [2:0] B_SQ   = 3'd2;
  localparam logic [2:0] B_ROOT = 3'd3;
  localparam logic [2:0] B_SUM  = 3'd4;
  localparam logic [2:0] B_DONE = 3'd5;

  logic [2:0]                         bstate;
  sem_pkg::job_t                      job;
  logic [2:0][sem_pkg::GRAD_W-1:0]    gx;
  logic [2:0][sem_pkg::GRAD_W-1:0]    gy;
  logic [2:0][sem_pkg::GRAD_W-1:0]    gx_next;
  logic [2:0][sem_pkg::GRAD_W-1:0]    gy_next;
  logic [2:0][sem_pkg::RAD_W-1:0]     rad;
  logic [2:0][sem_pkg::RAD_W-1:0]     rad_next;
  logic [2:0][sem_pkg::REM_W-1:0]     rem;
  logic [2:0][sem_pkg::REM_W-1:0]     rem_next;
  logic [2:0][sem_pkg::ROOT_W-1:0]    root;
  logic [2:0][sem_pkg::ROOT_W-1:0]    root_next;
  logic [2:0][sem_pkg::SQ_W-1:0]      sq_next;
  logic [sem_pkg::STEP_W-1:0]         step;
  logic [sem_pkg::PROD_W-1:0]         prod;
  logic [sem_pkg::SUM_W-1:0]          sum;
  logic                               load_out;

  assign pop = (bstate == B_IDLE) && (count != '0);

  // three lanes, one per color channel
  always_comb begin
    logic [sem_pkg::GRAD_W-1:0] lft, rgt, top, bot;
    logic [sem_pkg::CHAN_W-1:0] v [3][3];
    logic [sem_pkg::REM_W-1:0]  cand, test;
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          v[r][c] = job.win[r][c][(2-ch)*sem_pkg::CHAN_W +: sem_pkg::CHAN_W];
        end
      end
      lft = sem_pkg::GRAD_W'(v[0][0]) + {1'b0, v[1][0], 1'b0} + sem_pkg::GRAD_W'(v[2][0]);
      rgt = sem_pkg::GRAD_W'(v[0][2]) + {1'b0, v[1][2], 1'b0} + sem_pkg::GRAD_W'(v[2][2]);
      top = sem_pkg::GRAD_W'(v[0][0]) + {1'b0, v[0][1], 1'b0} + sem_pkg::GRAD_W'(v[0][2]);
      bot = sem_pkg::GRAD_W'(v[2][0]) + {1'b0, v[2][1], 1'b0} + sem_pkg::GRAD_W'(v[2][2]);
      gx_next[ch] = (lft >= rgt) ? lft - rgt : rgt - lft;
      gy_next[ch] = (top >= bot) ? top - bot : bot - top;
      sq_next[ch] = sem_pkg::SQ_W'(gx[ch]) * sem_pkg::SQ_W'(gx[ch]) +
                    sem_pkg::SQ_W'(gy[ch]) * sem_pkg::SQ_W'(gy[ch]);

      // one root bit per step: bring down two radicand bits, try subtract
      cand = {rem[ch][sem_pkg::REM_W-3:0], rad[ch][sem_pkg::RAD_W-1 -: 2]};
      test = sem_pkg::REM_W'({root[ch], 2'b01});
      rad_next[ch] = {rad[ch][sem_pkg::RAD_W-3:0], 2'b00};
      if (cand >= test) begin
        rem_next[ch]  = cand - test;
        root_next[ch] = {root[ch][sem_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[ch]  = cand;
        root_next[ch] = {root[ch][sem_pkg::ROOT_W-2:0], 1'b0};
      end
    end
    sum = sem_pkg::SUM_W'(root[0]) + sem_pkg::SUM_W'(root[1]) + sem_pkg::SUM_W'(root[2]);
  end

  assign load_out = (bstate == B_DONE) && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    case (bstate)
      B_GRAD: begin
        gx <= gx_next;
        gy <= gy_next;
      end
      B_SQ: begin
        for (int ch = 0; ch < 3; ch++) begin
          rad[ch] <= sem_pkg::RAD_W'(sq_next[ch]);
        end
        rem  <= '0;
        root <= '0;
      end
      B_ROOT: begin
        rad  <= rad_next;
        rem  <= rem_next;
        root <= root_next;
      end
      B_SUM: begin
        // floor divide by three through the reciprocal
        prod <= sem_pkg::PROD_W'(sum) * sem_pkg::PROD_W'(sem_pkg::DIV3_RECIP);
      end
      default: ;
    endcase
    if (load_out) begin
      result.energy    <= prod[sem_pkg::DIV3_SHIFT +: sem_pkg::ENERGY_W];
      result.row_end   <= job.row_end;
      result.frame_end <= job.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate       <= B_IDLE;
      step         <= '0;
      result.valid <= 1'b0;
    end else begin
      if (load_out) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (bstate)
        B_IDLE: if (pop) bstate <= B_GRAD;
        B_GRAD: bstate <= B_SQ;
        B_SQ: begin
          step   <= '0;
          bstate <= B_ROOT;
        end
        B_ROOT: begin
          if (step == sem_pkg::STEP_W'(sem_pkg::ROOT_W - 1)) begin
            bstate <= B_SUM;
          end else begin
            step <= step + sem_pkg::STEP_W'(1);
          end
        end
        B_SUM: bstate <= B_DONE;
        B_DONE: if (load_out) bstate <= B_IDLE;
        default: bstate <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sobel_rgb_energy_map_top.sv =====
// Sobel RGB energy map.
// pixel: valid/ready request channel, one RGB pixel per request in raster order;
//   action high marks a flush request that counts as a zero pixel.
// result: valid/ready channel, one energy value (mean of the three channel
//   gradient magnitudes) per frame pixel, with row_end and frame_end marks.
// cfg_we/cfg_index/cfg_data: register writes (0 frame_width, 1 frame_height);
//   any write restarts the frame. Write only while the block is idle.
// Results trail the input by frame_width+1 requests; after each frame send
// frame_width+1 flush requests to drain it.
// The front finishes each request (line store read, then write) before it takes
// the next, and takes none while the job queue is full. The back works on one
// result at a time through the 11-step square root lanes; a 2-entry job queue
// lets the two sides run apart. Requests that give no result cost the front only.
// Reset returns the registers to 1024 x 4096 and starts a new frame; the line
// stores are not cleared (rows outside the frame are masked).
// When the receiver stalls, the result register holds, the queue fills and
// then pixel.ready drops.
module sobel_rgb_energy_map_top (
  input  logic                             clk,
  input  logic                             rst,
  sem_pixel_if.sink                        pixel,
  sem_result_if.source                     result,
  input  logic                             cfg_we,
  input  logic [sem_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                          q_push;
  logic                          q_pop;
  sem_pkg::job_t                 q_in;
  sem_pkg::job_t                 q_head;
  logic [sem_pkg::QCNT_W-1:0]    q_count;
  logic                          q_space;

  assign q_space = (q_count < sem_pkg::QCNT_W'(sem_pkg::QUEUE_DEPTH));

  sem_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pixel    (pixel),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .space    (q_space),
    .push     (q_push),
    .push_job (q_in)
  );

  sem_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(q_in),
    .pop     (q_pop),
    .head    (q_head),
    .count   (q_count)
  );

  sem_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (q_head),
    .count (q_count),
    .pop   (q_pop),
    .result(result)
  );

`ifndef ASSERT_OFF
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready) |=> !pixel.ready)
    else $error("front accepted a request while busy");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count < sem_pkg::QCNT_W'(sem_pkg::QUEUE_DEPTH)))
    else $error("job queue overflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    q_count <= sem_pkg::QCNT_W'(sem_pkg::QUEUE_DEPTH))
    else $error("job queue count out of range");
`endif

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sem_pkg::*;

  typedef struct {
    logic [ENERGY_W-1:0] energy;
    logic                row_end;
    logic                frame_end;
  } energy_t;

  class energy_scoreboard;
    pixel_t    near_row[MAX_WIDTH];
    pixel_t    far_row[MAX_WIDTH];
    pixel_t    win[3][3];
    int unsigned width_reg, height_reg, col, row;
    energy_t   expected_q[$];
    int        errors;

    function new();
      width_reg = MAX_WIDTH;
      height_reg = MAX_HEIGHT;
      errors = 0;
      foreach (near_row[i]) begin
        near_row[i] = '0;
        far_row[i] = '0;
      end
      restart();
    endfunction

    function void restart();
      foreach (win[r, c]) win[r][c] = '0;
      col = 0;
      row = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FRAME_WIDTH) width_reg = data[WIDTH_REG_W-1:0];
      else if (idx == REG_FRAME_HEIGHT) height_reg = data[HEIGHT_REG_W-1:0];
      restart();
    endfunction

    function void shift_col(pixel_t t, pixel_t m, pixel_t b);
      pixel_t column[3];
      column[0] = t; column[1] = m; column[2] = b;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
        win[r][2] = column[r];
      end
    endfunction

    function int unsigned int_sqrt(int unsigned x);
      int unsigned res, bitv;
      res = 0;
      bitv = 1 << 30;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function int unsigned magnitude(int sh);
      int v[3][3];
      int gx, gy;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) v[r][c] = (win[r][c] >> sh) & 255;
      gx = (v[0][0] + 2 * v[1][0] + v[2][0]) - (v[0][2] + 2 * v[1][2] + v[2][2]);
      gy = (v[0][0] + 2 * v[0][1] + v[0][2]) - (v[2][0] + 2 * v[2][1] + v[2][2]);
      return int_sqrt(gx * gx + gy * gy);
    endfunction

    function int unsigned energy_now();
      return (magnitude(16) + magnitude(8) + magnitude(0)) / 3;
    endfunction

    function bit pending();
      return expected_q.size() != 0;
    endfunction

    function void note_pixel(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w, h, ci, ri, orow, ocol, e;
      pixel_t pix, t, m;
      bit got;
      energy_t x;
      w = width_reg < 2 ? 2 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
      h = height_reg < 2 ? 2 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
      ci = col >= w ? 0 : col;
      ri = row;
      got = 0;
      pix = (act || ri >= h) ? '0 : {r, g, b};
      if (ci == 0) begin
        if (ri >= 2) begin
          shift_col('0, '0, '0);
          e = energy_now();
          orow = ri - 2;
          ocol = w - 1;
          got = 1;
        end
        foreach (win[a, c]) win[a][c] = '0;
      end
      if (ci == 0 && ri >= h + 1) begin
        restart();
      end else begin
        t = ri >= 2 ? far_row[ci] : '0;
        m = ri >= 1 ? near_row[ci] : '0;
        far_row[ci] = near_row[ci];
        near_row[ci] = pix;
        shift_col(t, m, pix);
        if (ci != 0 && ri >= 1) begin
          e = energy_now();
          orow = ri - 1;
          ocol = ci - 1;
          got = 1;
        end
        ci++;
        if (ci >= w) begin
          ci = 0;
          ri++;
        end
        col = ci;
        row = ri;
      end
      if (got) begin
        x.energy = e[ENERGY_W-1:0];
        x.row_end = ocol == w - 1;
        x.frame_end = ocol == w - 1 && orow == h - 1;
        expected_q.push_back(x);
      end
    endfunction

    function void check_result(logic [ENERGY_W-1:0] e, logic re, logic fe);
      energy_t x;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result energy=%0d row_end=%0b frame_end=%0b",
                 $realtime, e, re, fe);
        errors++;
        return;
      end
      x = expected_q.pop_front();
      if (e !== x.energy) begin
        $display("%0t energy: expected %0d actual %0d", $realtime, x.energy, e);
        errors++;
      end
      if (re !== x.row_end) begin
        $display("%0t row_end: expected %0b actual %0b", $realtime, x.row_end, re);
        errors++;
      end
      if (fe !== x.frame_end) begin
        $display("%0t frame_end: expected %0b actual %0b", $realtime, x.frame_end, fe);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 5000;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  sem_pixel_if  pixel();
  sem_result_if result();

  sobel_rgb_energy_map_top u_top (
    .clk(clk), .rst(rst), .pixel(pixel), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  energy_scoreboard sb = new();
  int  sent;
  int  idle_cycles;
  bit  no_gaps;
  int  ready_hold;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver stalls: random stretches, sometimes long runs with no stall.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: begin
          result.ready <= 1'b0;
          ready_hold <= $urandom_range(0, 3);
        end
        2: begin
          result.ready <= 1'b0;
          ready_hold <= $urandom_range(10, 60);
        end
        3: begin
          result.ready <= 1'b1;
          ready_hold <= $urandom_range(50, 300);
        end
        default: begin
          result.ready <= 1'b1;
          ready_hold <= $urandom_range(0, 5);
        end
      endcase
    end
  end

  // Sample at the falling edge; the request moves at the next rising edge.
  always @(negedge clk) begin
    if (!rst && result.valid && result.ready)
      sb.check_result(result.energy, result.row_end, result.frame_end);
    if ((pixel.valid && pixel.ready) || (result.valid && result.ready) || rst || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_pixel(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      pixel.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel.valid  <= 1'b1;
    pixel.action <= act;
    pixel.red    <= r;
    pixel.green  <= g;
    pixel.blue   <= b;
    do @(negedge clk); while (!pixel.ready);
    sb.note_pixel(act, r, g, b);
    sent++;
    @(posedge clk);
  endtask

  task automatic send_random(logic act);
    send_pixel(act, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
  endtask

  // Drain all results, then allow the back end to settle before a write.
  task automatic drain();
    pixel.valid <= 1'b0;
    while (sb.pending()) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(int w, int h);
    drain();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
  endtask

  // Send a full frame of random pixels, then its flush; if noisy, odd items sprinkled in at random.
  task automatic frame_random(int w, int h, bit noisy);
    int wu, hu;
    wu = w < 2 ? 2 : (w > MAX_WIDTH ? MAX_WIDTH : w);
    hu = h < 2 ? 2 : (h > MAX_HEIGHT ? MAX_HEIGHT : h);
    for (int i = 0; i < wu * hu; i++)
      send_random(noisy && $urandom_range(0, 15) == 0);
    for (int i = 0; i <= wu; i++)
      send_random(!(noisy && $urandom_range(0, 3) == 0));
  endtask

  initial begin
    logic [7:0] lvl;
    int w, h;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_FRAME_WIDTH;
    cfg_data     = '0;
    pixel.valid  = 1'b0;
    pixel.action = 1'b0;
    pixel.red    = '0;
    pixel.green  = '0;
    pixel.blue   = '0;
    result.ready = 1'b0;
    ready_hold   = 0;
    sent         = 0;
    idle_cycles  = 0;
    no_gaps      = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 3x3 of channel extremes, a flush inside, a pixel in the flush.
    set_frame(3, 3);
    for (int i = 0; i < 9; i++) begin
      lvl = (i % 2) ? 8'hff : 8'h00;
      send_pixel(i == 4, lvl, ~lvl, (i < 3) ? 8'hff : 8'h00);
    end
    send_pixel(1'b0, 8'hff, 8'hff, 8'hff);
    repeat (3) send_pixel(1'b1, 8'hff, 8'hff, 8'hff);
    // Out-of-range sizes saturate.
    set_frame(0, 1);
    repeat (4) send_pixel(1'b0, 8'hff, 8'hff, 8'hff);
    repeat (3) send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    set_frame(1, 0);
    frame_random(2, 2, 0);

    // Random frames, mostly well formed and small.
    while (sent < 380) begin
      no_gaps = $urandom_range(0, 5) == 0;
      w = $urandom_range(2, 8);
      h = $urandom_range(2, 6);
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_reg(CFG_INDEX_W'($urandom_range(0, 1)), CFG_DATA_W'($urandom_range(0, 10)));
        w = sb.width_reg;
        h = sb.height_reg;
      end else if ($urandom_range(0, 3) != 0) begin
        set_frame(w, h);
      end else begin
        w = sb.width_reg;
        h = sb.height_reg;
      end
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 30)) send_random(1'($urandom_range(0, 1)));
        1: frame_random(w, h, 1);
        default: frame_random(w, h, 0);
      endcase
    end

    // Oversized width saturates: run past the first row into the second; then an oversized height.
    no_gaps = 0;
    set_frame(2047, 2);
    repeat (1100) send_random(1'b0);
    set_frame(2, 8191);
    repeat (20) send_random(1'b0);

    drain();
    if (sb.errors == 0 && !sb.pending()) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
